// ----- rtl/core/olc_pkg.sv -----
// olc_pkg: constants, register indexes and field widths for the occupancy light controller
// no dependencies; imported by occupancy_light_controller

package olc_pkg;

    // field widths
    localparam int unsigned LEVEL_W   = 10;
    localparam int unsigned HOURS_W   = 3;
    localparam int unsigned DELAY_W   = 16;
    localparam int unsigned RELEASE_W = 8;
    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned OUT_DATA_W = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam int unsigned DEFAULT_COUNTER_WIDTH = 16;

    // time-of-day cascade wrap points
    localparam logic [9:0]         MS_WRAP   = 10'd999;
    localparam logic [5:0]         SEC_WRAP  = 6'd59;
    localparam logic [5:0]         MIN_WRAP  = 6'd59;
    localparam logic [HOURS_W-1:0] HOURS_TOP = 3'd7;

    // register reset values
    localparam logic [RELEASE_W-1:0] RELEASE_TICKS_RST  = 8'd25;
    localparam logic [DELAY_W-1:0]   HOLD_TICKS_RST     = 16'd2000;
    localparam logic [DELAY_W-1:0]   MOTION_DELAY_RST   = 16'd3000;
    localparam logic [DELAY_W-1:0]   DARK_OFF_DELAY_RST = 16'd5000;
    localparam logic [HOURS_W-1:0]   CUTOFF_HOURS_RST   = 3'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RELEASE_TICKS  = 3'd0,
        CFG_HOLD_TICKS     = 3'd1,
        CFG_MOTION_DELAY   = 3'd2,
        CFG_DARK_OFF_DELAY = 3'd3,
        CFG_CUTOFF_HOURS   = 3'd4
    } cfg_idx_t;

endpackage

// ----- rtl/core/occupancy_light_controller.sv -----
// occupancy_light_controller: per-tick switch debounce, hour timer and bulb decision
// depends on olc_pkg

// One input beat is one 1 ms tick carrying the switch and motion pin levels, a light
// reading and a threshold; one output beat comes back for every input beat, carrying the
// bulb drive, the debounced switch state and the hours counted while the switch is held.
// The block takes one beat per clock cycle while results are taken: an accepted beat lands in an
// input register, then a single pass of logic updates all state registers, and those state
// registers are the result register, so the result is registered after the input register.
// The only limit on rate is the output side: while a result waits on m_tready the input
// register can still take one more beat, after which s_tready drops.
// Configuration writes (cfg_index 0..4: release_ticks, hold_ticks, motion_delay,
// dark_off_delay, cutoff_hours) are always accepted and should be issued while no beat is
// in flight; indexes past the list are ignored.
module occupancy_light_controller
    import olc_pkg::*;
#(
    parameter int unsigned COUNTER_WIDTH = DEFAULT_COUNTER_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [0] switch_level, [1] pir_level, [11:2] light_reading, [21:12] threshold, [23:22] zero
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] bulb_on, [1] switch_active, [4:2] hours_elapsed, [7:5] zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // width used to compare the saturating counters against the 16-bit delays
    localparam int unsigned CMP_W = (COUNTER_WIDTH > DELAY_W) ? COUNTER_WIDTH : DELAY_W;

    // configuration registers
    logic [RELEASE_W-1:0] release_ticks_reg;
    logic [DELAY_W-1:0]   hold_ticks_reg;
    logic [DELAY_W-1:0]   motion_delay_reg;
    logic [DELAY_W-1:0]   dark_off_delay_reg;
    logic [HOURS_W-1:0]   cutoff_hours_reg;

    // input register
    logic               in_valid_reg;
    logic               in_switch_reg;
    logic               in_pir_reg;
    logic [LEVEL_W-1:0] in_light_reg;
    logic [LEVEL_W-1:0] in_thr_reg;

    // controller state, which doubles as the result register
    logic                     out_valid_reg;
    logic [RELEASE_W-1:0]     release_cnt_reg, release_cnt_next;
    logic                     switch_flag_reg, switch_flag_next;
    logic [DELAY_W-1:0]       hold_count_reg, hold_count_next;
    logic [9:0]               millis_reg, millis_next;
    logic [5:0]               secs_reg, secs_next;
    logic [5:0]               mins_reg, mins_next;
    logic [HOURS_W-1:0]       hours_reg, hours_next;
    logic [COUNTER_WIDTH-1:0] motion_cnt_reg, motion_cnt_next;
    logic [COUNTER_WIDTH-1:0] dark_cnt_reg, dark_cnt_next;
    logic                     bulb_reg, bulb_next;

    logic advance;

    // handshakes: the state steps only when the result register is free to take the result
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {3'b000, hours_reg, switch_flag_reg, bulb_reg};

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            release_ticks_reg  <= RELEASE_TICKS_RST;
            hold_ticks_reg     <= HOLD_TICKS_RST;
            motion_delay_reg   <= MOTION_DELAY_RST;
            dark_off_delay_reg <= DARK_OFF_DELAY_RST;
            cutoff_hours_reg   <= CUTOFF_HOURS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RELEASE_TICKS:  release_ticks_reg  <= cfg_data[RELEASE_W-1:0];
                CFG_HOLD_TICKS:     hold_ticks_reg     <= cfg_data[DELAY_W-1:0];
                CFG_MOTION_DELAY:   motion_delay_reg   <= cfg_data[DELAY_W-1:0];
                CFG_DARK_OFF_DELAY: dark_off_delay_reg <= cfg_data[DELAY_W-1:0];
                CFG_CUTOFF_HOURS:   cutoff_hours_reg   <= cfg_data[HOURS_W-1:0];
                default:            ;
            endcase
        end
    end

    // input register: valid flag is control, payload needs no reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_switch_reg <= s_tdata[0];
            in_pir_reg    <= s_tdata[1];
            in_light_reg  <= s_tdata[2 +: LEVEL_W];
            in_thr_reg    <= s_tdata[2 + LEVEL_W +: LEVEL_W];
        end
    end

    // one tick of controller logic
    always_comb
    begin
        logic                 motion;
        logic                 bright;
        logic                 lit;
        logic [DELAY_W:0]     hold_inc;
        logic [9:0]           ms_inc;
        logic [5:0]           sec_inc;
        logic [5:0]           min_inc;
        logic [HOURS_W:0]     hour_inc;
        logic [CMP_W-1:0]     motion_ext;
        logic [CMP_W-1:0]     dark_ext;
        logic                 forced;

        motion = !in_pir_reg;
        bright = (in_light_reg >= in_thr_reg);
        lit    = bulb_reg;

        // switch debounce: low pin is immediate, high pin must outlast the countdown
        release_cnt_next = release_cnt_reg;
        switch_flag_next = switch_flag_reg;
        if (in_switch_reg)
        begin
            if (release_cnt_reg != '0)
            begin
                release_cnt_next = release_cnt_reg - {{(RELEASE_W-1){1'b0}}, 1'b1};
            end
            else
            begin
                switch_flag_next = 1'b0;
                release_cnt_next = release_ticks_reg;
            end
        end
        else
        begin
            switch_flag_next = 1'b1;
            release_cnt_next = release_ticks_reg;
        end

        // hold counter and ms/s/min/h cascade
        hold_count_next = hold_count_reg;
        millis_next     = millis_reg;
        secs_next       = secs_reg;
        mins_next       = mins_reg;
        hours_next      = hours_reg;
        hold_inc = {1'b0, hold_count_reg} + {{DELAY_W{1'b0}}, 1'b1};
        ms_inc   = millis_reg + 10'd1;
        sec_inc  = secs_reg + 6'd1;
        min_inc  = mins_reg + 6'd1;
        hour_inc = {1'b0, hours_reg} + {{HOURS_W{1'b0}}, 1'b1};
        if (switch_flag_next)
        begin
            if (hold_inc >= {1'b0, hold_ticks_reg})
            begin
                hold_count_next = hold_ticks_reg;
                millis_next     = ms_inc;
                if (ms_inc == MS_WRAP)
                begin
                    millis_next = '0;
                    secs_next   = sec_inc;
                    if (sec_inc == SEC_WRAP)
                    begin
                        secs_next = '0;
                        mins_next = min_inc;
                        if (min_inc == MIN_WRAP)
                        begin
                            mins_next = '0;
                            if (hour_inc > {1'b0, cutoff_hours_reg})
                            begin
                                hours_next = HOURS_TOP;
                            end
                            else
                            begin
                                hours_next = hour_inc[HOURS_W-1:0];
                            end
                        end
                    end
                end
            end
            else
            begin
                hold_count_next = hold_inc[DELAY_W-1:0];
            end
        end
        else
        begin
            hold_count_next = '0;
            millis_next     = '0;
            secs_next       = '0;
            mins_next       = '0;
            hours_next      = '0;
        end

        // saturating motion and dark counters; the dark counter is judged against last tick's bulb
        if (motion && !switch_flag_next && bright)
        begin
            motion_cnt_next = (motion_cnt_reg == '1) ? motion_cnt_reg
                            : motion_cnt_reg + {{(COUNTER_WIDTH-1){1'b0}}, 1'b1};
        end
        else
        begin
            motion_cnt_next = '0;
        end
        if (motion && !bright && lit)
        begin
            dark_cnt_next = (dark_cnt_reg == '1) ? dark_cnt_reg
                          : dark_cnt_reg + {{(COUNTER_WIDTH-1){1'b0}}, 1'b1};
        end
        else
        begin
            dark_cnt_next = '0;
        end
        motion_ext = CMP_W'(motion_cnt_next);
        dark_ext   = CMP_W'(dark_cnt_next);

        // bulb priority chain
        forced = switch_flag_next && (hold_count_next >= hold_ticks_reg)
              && (hours_next < cutoff_hours_reg);
        bulb_next = bulb_reg;
        if (forced)
        begin
            bulb_next = 1'b1;
        end
        else if (bright && motion && (motion_ext >= CMP_W'(motion_delay_reg)))
        begin
            bulb_next = 1'b1;
        end
        else if (motion && !bright && lit && (dark_ext > CMP_W'(dark_off_delay_reg)))
        begin
            bulb_next = 1'b0;
        end
        else if (motion && bright && lit)
        begin
            bulb_next = 1'b1;
        end
        else if (!motion)
        begin
            bulb_next = 1'b0;
        end
    end

    // state update doubles as loading the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            release_cnt_reg <= RELEASE_TICKS_RST;
            switch_flag_reg <= 1'b0;
            hold_count_reg  <= '0;
            millis_reg      <= '0;
            secs_reg        <= '0;
            mins_reg        <= '0;
            hours_reg       <= '0;
            motion_cnt_reg  <= '0;
            dark_cnt_reg    <= '0;
            bulb_reg        <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg   <= 1'b1;
                release_cnt_reg <= release_cnt_next;
                switch_flag_reg <= switch_flag_next;
                hold_count_reg  <= hold_count_next;
                millis_reg      <= millis_next;
                secs_reg        <= secs_next;
                mins_reg        <= mins_next;
                hours_reg       <= hours_next;
                motion_cnt_reg  <= motion_cnt_next;
                dark_cnt_reg    <= dark_cnt_next;
                bulb_reg        <= bulb_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    // cascade digits never reach their wrap values
    assert property (@(posedge clk) disable iff (!rst_n)
        (millis_reg < MS_WRAP) && (secs_reg < SEC_WRAP) && (mins_reg < MIN_WRAP))
        else $error("time cascade out of range");

    // a released switch leaves the hold counter and hours cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        !switch_flag_reg |-> (hold_count_reg == '0) && (hours_reg == '0) && (millis_reg == '0))
        else $error("counters not cleared on release");

    // input side stalls only behind a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a waiting result");

    // a processed tick always produces a result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("processed tick without result");
`endif

endmodule
